// File: hdl/bfhs_pkg.sv
package bfhs_pkg;

   localparam int PAGE_BITS  = 32;
   localparam int STEP_BITS  = 8;
   localparam int COUNT_BITS = 8;

   typedef enum logic [1:0] {
      OP_VISIT   = 2'd0,
      OP_BACK    = 2'd1,
      OP_FORWARD = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MOVE,
      ST_LOAD,
      ST_FINISH
   } state_type;

   typedef struct packed {
      op_type                 operation;
      logic [PAGE_BITS-1:0]   page_id;
      logic [STEP_BITS-1:0]   steps;
   } req_type;

   typedef struct packed {
      logic                   ok;
      logic                   current_valid;
      logic [PAGE_BITS-1:0]   active_page;
      logic [COUNT_BITS-1:0]  back_count;
      logic [COUNT_BITS-1:0]  forward_count;
   } rsp_type;

   // one command per stack per cycle
   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } stack_cmd_type;

endpackage

// File: hdl/bfhs_stack.sv
module bfhs_stack
   import bfhs_pkg::*;
#(
   parameter int DEPTH = 128,
   localparam int LEVEL_W = $clog2(DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  stack_cmd_type         cmd,
   input  logic [PAGE_BITS-1:0]  wr_page,
   output logic [LEVEL_W-1:0]    level,
   output logic [PAGE_BITS-1:0]  rd_page
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int SUM_W = LEVEL_W + 1;

   logic [PAGE_BITS-1:0] mem_ff [DEPTH];
   logic [PAGE_BITS-1:0] rd_page_ff;
   logic [PTR_W-1:0]     base_ff, base_in;
   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic [SUM_W-1:0]     sum_top, sum_pop;
   logic [PTR_W-1:0]     wr_idx, rd_idx;
   logic                 full;

   // ring buffer: oldest entry at base, a push on a full ring overwrites it
   always_comb begin
      sum_top = SUM_W'(base_ff) + SUM_W'(level_ff);
      sum_pop = sum_top - SUM_W'(1);
      wr_idx  = (sum_top >= SUM_W'(DEPTH)) ? PTR_W'(sum_top - SUM_W'(DEPTH)) : PTR_W'(sum_top);
      rd_idx  = (sum_pop >= SUM_W'(DEPTH)) ? PTR_W'(sum_pop - SUM_W'(DEPTH)) : PTR_W'(sum_pop);
      full    = (level_ff == LEVEL_W'(DEPTH));
   end

   always_comb begin
      base_in  = base_ff;
      level_in = level_ff;
      priority if (cmd.clear) begin
         level_in = '0;
      end else if (cmd.push) begin
         if (full) begin
            base_in = (base_ff == PTR_W'(DEPTH - 1)) ? '0 : base_ff + PTR_W'(1);
         end else begin
            level_in = level_ff + LEVEL_W'(1);
         end
      end else if (cmd.pop) begin
         level_in = level_ff - LEVEL_W'(1);
      end else begin
         // hold
         level_in = level_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         level_ff <= '0;
      end else begin
         base_ff  <= base_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem_ff[wr_idx] <= wr_page;
      end
      if (cmd.pop) begin
         rd_page_ff <= mem_ff[rd_idx];
      end
   end

   assign level   = level_ff;
   assign rd_page = rd_page_ff;

`ifndef ASSERT_OFF
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> level_ff != '0)
      else $error("pop from empty stack");

   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      !(cmd.push && cmd.pop))
      else $error("push and pop in one cycle");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LEVEL_W'(DEPTH))
      else $error("stack level beyond depth");
`endif

endmodule

// File: hdl/back_forward_history_stacks_core.sv
// Back/forward navigation history: a current page plus two bounded stacks.
// Request channel (req_valid/req_ready/req_data): one operation each, visit,
// back n, forward n or clear. Response channel (rsp_valid/rsp_ready/rsp_data):
// exactly one response per request with ok, the current page and both counts.
// The block works on one request at a time; req_ready is high only when idle.
// Back or forward moves k entries, where k is the step count (0 counts as
// 1) cut short when the source stack runs empty, so k never exceeds DEPTH.
// req_ready rises again in the same cycle as rsp_valid, since the output
// register loads as the block returns to idle.
// Each moved entry passes through ST_MOVE, which pops through the stack
// memory's registered read port while pushing onto the other stack, and then
// ST_LOAD, which loads the popped page as current.
// The response sits in an output register; a stalled receiver holds the
// finished response, and the block is idle again once it has been taken or
// the register was free. Reset empties both stacks and drops the current page
// at once; there is no clearing pass over the memories.
module back_forward_history_stacks_core
   import bfhs_pkg::*;
#(
   parameter int DEPTH = 128
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int LEVEL_W = $clog2(DEPTH + 1);

   state_type             state_ff, state_in;
   req_type               req_ff, req_in;
   logic                  ok_ff, ok_in;
   logic [STEP_BITS-1:0]  remaining_ff, remaining_in;
   logic [PAGE_BITS-1:0]  present_page_ff, present_page_in;
   logic                  present_valid_ff, present_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_load;

   stack_cmd_type         back_cmd, fwd_cmd;
   logic [LEVEL_W-1:0]    back_level, fwd_level;
   logic [PAGE_BITS-1:0]  back_rd, fwd_rd;
   logic                  going_back;
   logic [LEVEL_W-1:0]    src_level;

   bfhs_stack #(.DEPTH(DEPTH)) u_back (
      .clock   (clock),
      .reset   (reset),
      .cmd     (back_cmd),
      .wr_page (present_page_ff),
      .level   (back_level),
      .rd_page (back_rd)
   );

   bfhs_stack #(.DEPTH(DEPTH)) u_fwd (
      .clock   (clock),
      .reset   (reset),
      .cmd     (fwd_cmd),
      .wr_page (present_page_ff),
      .level   (fwd_level),
      .rd_page (fwd_rd)
   );

   assign going_back = (req_ff.operation == OP_BACK);
   assign src_level  = going_back ? back_level : fwd_level;

   always_comb begin
      state_in         = state_ff;
      req_in           = req_ff;
      ok_in            = ok_ff;
      remaining_in     = remaining_ff;
      present_page_in  = present_page_ff;
      present_valid_in = present_valid_ff;
      back_cmd         = '0;
      fwd_cmd          = '0;
      rsp_load         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            // latch the request
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            remaining_in = (req_ff.steps == '0) ? STEP_BITS'(1) : req_ff.steps;
            unique case (req_ff.operation)
               OP_VISIT: begin
                  back_cmd.push    = present_valid_ff;
                  fwd_cmd.clear    = 1'b1;
                  present_page_in  = req_ff.page_id;
                  present_valid_in = 1'b1;
                  ok_in            = 1'b1;
                  state_in         = ST_FINISH;
               end
               OP_BACK: begin
                  ok_in    = present_valid_ff && (back_level != '0);
                  state_in = ok_in ? ST_MOVE : ST_FINISH;
               end
               OP_FORWARD: begin
                  ok_in    = (fwd_level != '0);
                  state_in = ok_in ? ST_MOVE : ST_FINISH;
               end
               OP_CLEAR: begin
                  back_cmd.clear   = 1'b1;
                  fwd_cmd.clear    = 1'b1;
                  present_valid_in = 1'b0;
                  ok_in            = 1'b1;
                  state_in         = ST_FINISH;
               end
               default: state_in = ST_FINISH;
            endcase
         end
         ST_MOVE: begin
            // stop when the count is used up or the source runs dry
            if (remaining_ff == '0 || src_level == '0) begin
               state_in = ST_FINISH;
            end else begin
               if (going_back) begin
                  fwd_cmd.push = 1'b1;
                  back_cmd.pop = 1'b1;
               end else begin
                  back_cmd.push = present_valid_ff;
                  fwd_cmd.pop   = 1'b1;
               end
               remaining_in = remaining_ff - STEP_BITS'(1);
               state_in     = ST_LOAD;
            end
         end
         ST_LOAD: begin
            present_page_in  = going_back ? back_rd : fwd_rd;
            present_valid_in = 1'b1;
            state_in         = ST_MOVE;
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_in.ok            = ok_ff;
      rsp_in.current_valid = present_valid_ff;
      rsp_in.active_page   = present_valid_ff ? present_page_ff : '0;
      rsp_in.back_count    = COUNT_BITS'(back_level);
      rsp_in.forward_count = COUNT_BITS'(fwd_level);

      priority if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         present_valid_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         present_valid_ff <= present_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff          <= req_in;
      ok_ff           <= ok_in;
      remaining_ff    <= remaining_in;
      present_page_ff <= present_page_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == ST_EXEC)
      else $error("accepted request not executed");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |=> present_valid_ff)
      else $error("popped page not marked current");

   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && req_ff.operation == OP_CLEAR)
      |-> (back_level == '0 && fwd_level == '0 && !present_valid_ff))
      else $error("clear left history behind");

   a_move_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOVE || state_ff == ST_LOAD) |-> ok_ff)
      else $error("move after failed check");
`endif

endmodule

// File: tb/tb_back_forward_history_stacks_core.sv
module tb_back_forward_history_stacks_core
   import bfhs_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = 128;
   localparam int RANDOM_ITEMS = 1730;
   // Slowest correct item: a move across the full depth, plus the longest
   // sender gap and receiver stall. Allow several times that.
   localparam int QUIET_LIMIT  = 4000;
   // Settle time after the last response: longer than the worst move.
   localparam int TAIL_CYCLES  = 600;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   back_forward_history_stacks_core #(
      .DEPTH(DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // Directed request table. Rows with has_view set carry a hand-written
   // response; all other rows are checked against the history predictor.
   typedef struct packed {
      op_type      op;
      logic [31:0] page;
      logic [7:0]  steps;
      logic        has_view;
      rsp_type     view;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 19;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      // back right after reset: nothing behind, no current page
      '{OP_BACK,    32'h0000_0000, 8'd1,   1'b1, '{1'b0, 1'b0, 32'h0, 8'd0, 8'd0}},
      // forward with zero steps and nothing ahead
      '{OP_FORWARD, 32'h0000_0000, 8'd0,   1'b1, '{1'b0, 1'b0, 32'h0, 8'd0, 8'd0}},
      // clear on an empty history still succeeds
      '{OP_CLEAR,   32'hFFFF_FFFF, 8'd255, 1'b1, '{1'b1, 1'b0, 32'h0, 8'd0, 8'd0}},
      // first visit: no current page to push, lowest page id
      '{OP_VISIT,   32'h0000_0000, 8'd0,   1'b1, '{1'b1, 1'b1, 32'h0, 8'd0, 8'd0}},
      // highest page id; previous page goes behind
      '{OP_VISIT,   32'hFFFF_FFFF, 8'd255, 1'b1,
        '{1'b1, 1'b1, 32'hFFFF_FFFF, 8'd1, 8'd0}},
      '{OP_VISIT,   32'hA5A5_A5A5, 8'd7,   1'b0, '0},
      '{OP_VISIT,   32'h5A5A_5A5A, 8'd128, 1'b0, '0},
      // zero steps moves one entry
      '{OP_BACK,    32'h1234_5678, 8'd0,   1'b0, '0},
      // oversized move stops when the back stack runs dry
      '{OP_BACK,    32'h0000_0000, 8'd255, 1'b0, '0},
      // nothing behind any more
      '{OP_BACK,    32'h0000_0000, 8'd1,   1'b0, '0},
      '{OP_FORWARD, 32'hFFFF_FFFF, 8'd2,   1'b0, '0},
      '{OP_FORWARD, 32'h0000_0000, 8'd255, 1'b0, '0},
      // nothing ahead any more
      '{OP_FORWARD, 32'h0000_0000, 8'd1,   1'b0, '0},
      '{OP_BACK,    32'h0000_0000, 8'd128, 1'b0, '0},
      // visit in the middle of the history drops everything ahead
      '{OP_VISIT,   32'h0000_0001, 8'd0,   1'b0, '0},
      '{OP_CLEAR,   32'h0000_0000, 8'd0,   1'b1, '{1'b1, 1'b0, 32'h0, 8'd0, 8'd0}},
      // back and forward with no current page
      '{OP_BACK,    32'h0000_0000, 8'd3,   1'b1, '{1'b0, 1'b0, 32'h0, 8'd0, 8'd0}},
      '{OP_FORWARD, 32'h0000_0000, 8'd3,   1'b1, '{1'b0, 1'b0, 32'h0, 8'd0, 8'd0}},
      '{OP_VISIT,   32'h8000_0000, 8'd1,   1'b0, '0}
   };

   // Predicted history: oldest entry at the front of each queue.
   logic [31:0] pages_behind [$];
   logic [31:0] pages_ahead [$];
   logic [31:0] shown_page;
   logic        shown_valid;

   // Responses still owed by the block, oldest first.
   rsp_type     owed_views [$];

   int          mismatches;
   int          quiet_cycles;
   bit          sender_eager;
   bit          receiver_eager;

   // Push onto the back stack; drop the oldest entry when it is full.
   function automatic void remember_behind(logic [31:0] page);
      if (pages_behind.size() >= DEPTH) begin
         void'(pages_behind.pop_front());
      end
      pages_behind.push_back(page);
   endfunction

   // Apply one request to the predicted history and return the response.
   function automatic rsp_type navigate_history(req_type r);
      rsp_type v;
      int      moves;
      int      i;
      moves = (r.steps == 0) ? 1 : int'(r.steps);
      v = '0;
      v.ok = 1'b1;
      case (r.operation)
         OP_VISIT: begin
            if (shown_valid) begin
               remember_behind(shown_page);
            end
            pages_ahead.delete();
            shown_page  = r.page_id;
            shown_valid = 1'b1;
         end
         OP_BACK: begin
            if (!shown_valid || pages_behind.size() == 0) begin
               v.ok = 1'b0;
            end else begin
               for (i = 0; i < moves && pages_behind.size() != 0; i++) begin
                  if (pages_ahead.size() >= DEPTH) begin
                     void'(pages_ahead.pop_front());
                  end
                  pages_ahead.push_back(shown_page);
                  shown_page = pages_behind.pop_back();
               end
            end
         end
         OP_FORWARD: begin
            if (pages_ahead.size() == 0) begin
               v.ok = 1'b0;
            end else begin
               for (i = 0; i < moves && pages_ahead.size() != 0; i++) begin
                  if (shown_valid) begin
                     remember_behind(shown_page);
                  end
                  shown_page  = pages_ahead.pop_back();
                  shown_valid = 1'b1;
               end
            end
         end
         default: begin
            pages_behind.delete();
            pages_ahead.delete();
            shown_valid = 1'b0;
         end
      endcase
      v.current_valid = shown_valid;
      v.active_page   = shown_valid ? shown_page : '0;
      v.back_count    = COUNT_BITS'(pages_behind.size());
      v.forward_count = COUNT_BITS'(pages_ahead.size());
      return v;
   endfunction

   task automatic flag_mismatch(string what);
      $display("%0t mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   // Compare one taken response with the oldest one owed.
   task automatic check_view(rsp_type got);
      rsp_type want;
      if (owed_views.size() == 0) begin
         flag_mismatch($sformatf("response %h with none pending", got));
         return;
      end
      want = owed_views.pop_front();
      if (got.ok !== want.ok)
         flag_mismatch($sformatf("ok %b, want %b", got.ok, want.ok));
      if (got.current_valid !== want.current_valid)
         flag_mismatch($sformatf("current_valid %b, want %b",
                                 got.current_valid, want.current_valid));
      if (got.active_page !== want.active_page)
         flag_mismatch($sformatf("active_page %h, want %h",
                                 got.active_page, want.active_page));
      if (got.back_count !== want.back_count)
         flag_mismatch($sformatf("back_count %0d, want %0d",
                                 got.back_count, want.back_count));
      if (got.forward_count !== want.forward_count)
         flag_mismatch($sformatf("forward_count %0d, want %0d",
                                 got.forward_count, want.forward_count));
   endtask

   // Offer one request; called at a falling edge, returns at a falling edge
   // once the request has been taken. Valid stays high across back-to-back
   // requests, so this task only lowers it when a gap is drawn.
   task automatic offer_request(req_type r, logic has_view, rsp_type view);
      int      gap;
      rsp_type want;
      gap = sender_eager ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      // Predict on acceptance; a hand-written view overrides the prediction.
      want = navigate_history(r);
      owed_views.push_back(has_view ? view : want);
      @(negedge clock);
   endtask

   // Step counts: mostly short moves, some medium, a few across the range.
   function automatic logic [7:0] draw_steps();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 75) return 8'($urandom_range(0, 7));
      if (pick < 93) return 8'($urandom_range(8, 40));
      return 8'($urandom_range(0, 255));
   endfunction

   // Ordinary browsing: visits interleaved with back and forward moves, and a rare clear.
   function automatic req_type draw_browse_request();
      req_type r;
      int      pick;
      pick = $urandom_range(0, 99);
      r.page_id = $urandom();
      r.steps   = draw_steps();
      if (pick < 40)      r.operation = OP_VISIT;
      else if (pick < 70) r.operation = OP_BACK;
      else if (pick < 98) r.operation = OP_FORWARD;
      else                r.operation = OP_CLEAR;
      return r;
   endfunction

   // Drain the block: drop valid, then hold off until every owed response
   // has been taken. Called at a falling edge, returns at a later one.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (owed_views.size() != 0);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Response side: stall a random number of cycles before each response,
   // with occasional stretches of no stall at all.
   initial begin
      int stall;
      int taken;
      rsp_ready      = 1'b0;
      receiver_eager = 1'b0;
      taken          = 0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (taken % 64 == 0) begin
            receiver_eager = ($urandom_range(0, 3) == 0);
         end
         stall = receiver_eager ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         check_view(rsp_data);
         taken++;
         @(negedge clock);
      end
   end

   // Watchdog: end the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("tb_back_forward_history_stacks_core: errors");
               $finish;
            end
         end
      end
   end

   initial begin
      req_type r;
      int      sent;
      int      run;
      int      mode;
      int      k;

      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      mismatches   = 0;
      quiet_cycles = 0;
      sender_eager = 1'b0;
      shown_page   = '0;
      shown_valid  = 1'b0;

      // Hold reset, then release it on a falling edge.
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: walk the table.
      foreach (directed_rows[i]) begin
         r.operation = directed_rows[i].op;
         r.page_id   = directed_rows[i].page;
         r.steps     = directed_rows[i].steps;
         offer_request(r, directed_rows[i].has_view, directed_rows[i].view);
      end

      // Random part, in bursts. The first burst always fills the back stack
      // past its depth so the oldest-entry drop is exercised early.
      sent = 0;
      mode = 0;
      while (sent < RANDOM_ITEMS) begin
         sender_eager = ($urandom_range(0, 3) == 0);
         case (mode)
            0: begin
               // Long visit run: overflow the back stack, then walk it.
               run = $urandom_range(DEPTH + 1, DEPTH + 12);
               for (k = 0; k < run; k++) begin
                  r.operation = OP_VISIT;
                  r.page_id   = $urandom();
                  r.steps     = 8'($urandom_range(0, 255));
                  offer_request(r, 1'b0, '0);
                  sent++;
               end
               r.operation = OP_BACK;
               r.steps     = 8'($urandom_range(100, 255));
               offer_request(r, 1'b0, '0);
               r.operation = OP_FORWARD;
               r.steps     = 8'($urandom_range(0, 255));
               offer_request(r, 1'b0, '0);
               sent += 2;
            end
            1: begin
               // Noise: any operation, any step count.
               run = $urandom_range(5, 20);
               for (k = 0; k < run; k++) begin
                  r.operation = op_type'($urandom_range(0, 3));
                  r.page_id   = $urandom();
                  r.steps     = 8'($urandom_range(0, 255));
                  offer_request(r, 1'b0, '0);
                  sent++;
               end
            end
            default: begin
               run = $urandom_range(10, 40);
               for (k = 0; k < run; k++) begin
                  r = draw_browse_request();
                  offer_request(r, 1'b0, '0);
                  sent++;
               end
            end
         endcase
         // Pause the sender now and then until the block has caught up.
         if ($urandom_range(0, 9) == 0) begin
            wait_for_drain();
         end
         k = $urandom_range(0, 9);
         mode = (k == 0) ? 0 : (k == 1) ? 1 : 2;
      end
      // Make sure at least one full drain pause happened late in the run.
      wait_for_drain();
      r.operation = OP_CLEAR;
      r.page_id   = $urandom();
      r.steps     = 8'($urandom_range(0, 255));
      offer_request(r, 1'b0, '0);

      // Drain, then give the block time to show any stray response.
      wait_for_drain();
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatches == 0) begin
         $display("tb_back_forward_history_stacks_core: clean");
      end else begin
         $display("tb_back_forward_history_stacks_core: errors");
      end
      $finish;
   end

endmodule
